[hdl/ubxfr_pkg.sv]
// Shared types and constants of the binary GPS frame receiver.
package ubxfr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC2,
    PH_HEAD,
    PH_DATA,
    PH_CRCA,
    PH_CRCB
  } phase_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_NOT_FRAME = 3'd1,
    ST_GOOD      = 3'd2,
    ST_CSUM_ERR  = 3'd3,
    ST_GOOD_ACK  = 3'd4
  } frame_status_t;

  typedef enum logic [1:0] {
    ACK_NONE = 2'd0,
    ACK_ACK  = 2'd1,
    ACK_NAK  = 2'd2
  } ack_res_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CLASS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_ID = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NAK_ID = 3'd4;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] ack_class_code;
    logic [7:0] ack_id_code;
    logic [7:0] nak_id_code;
  } cfg_t;

  typedef struct packed {
    frame_status_t status;
    logic          payload_valid;
    logic [7:0]    payload_byte;
    logic [15:0]   payload_index;
    logic [7:0]    frame_class;
    logic [7:0]    frame_id;
    logic [15:0]   frame_length;
    ack_res_t      ack_result;
  } res_t;

endpackage

[hdl/ubxfr_cfg_regs.sv]
// Configuration register file of the frame receiver.
module ubxfr_cfg_regs import ubxfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  cfg_nxt.sync_first = cfg_data;
        CFG_SYNC_SECOND: cfg_nxt.sync_second = cfg_data;
        CFG_ACK_CLASS:   cfg_nxt.ack_class_code = cfg_data;
        CFG_ACK_ID:      cfg_nxt.ack_id_code = cfg_data;
        CFG_NAK_ID:      cfg_nxt.nak_id_code = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first <= 8'd181;
      cfg_r.sync_second <= 8'd98;
      cfg_r.ack_class_code <= 8'd5;
      cfg_r.ack_id_code <= 8'd1;
      cfg_r.nak_id_code <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/ubxfr_parser.sv]
// Frame parsing state machine, checksum and acknowledge tracking.
module ubxfr_parser import ubxfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       opcode,
  input  logic [7:0] rx_byte,
  input  logic [7:0] sent_class,
  input  logic [7:0] sent_id,
  input  cfg_t       cfg,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic        first_bad_r, first_bad_nxt;
  logic        ack_pending_r, ack_pending_nxt;
  logic        ack_matches_r, ack_matches_nxt;
  logic [7:0]  exp_class_r, exp_class_nxt;
  logic [7:0]  exp_id_r, exp_id_nxt;

  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] count_inc;
  logic [15:0] full_length;

  assign sum_a_add = sum_a_r + rx_byte;
  assign sum_b_add = sum_b_r + sum_a_add;
  assign count_inc = byte_count_r + 16'd1;
  assign full_length = {rx_byte, length_r[7:0]};

  always_comb begin
    phase_nxt = phase_r;
    if (opcode == OP_BYTE) begin
      case (phase_r)
        PH_IDLE:  if (rx_byte == cfg.sync_first) phase_nxt = PH_SYNC2;
        PH_SYNC2: phase_nxt = (rx_byte == cfg.sync_second) ? PH_HEAD : PH_IDLE;
        PH_HEAD: begin
          if (byte_count_r > 16'd2) begin
            phase_nxt = (full_length == 16'd0) ? PH_CRCA : PH_DATA;
          end
        end
        PH_DATA:  if (count_inc >= length_r) phase_nxt = PH_CRCA;
        PH_CRCA:  phase_nxt = PH_CRCB;
        PH_CRCB:  phase_nxt = PH_IDLE;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    length_nxt = length_r;
    class_nxt = class_r;
    id_nxt = id_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    first_bad_nxt = first_bad_r;
    ack_pending_nxt = ack_pending_r;
    ack_matches_nxt = ack_matches_r;
    exp_class_nxt = exp_class_r;
    exp_id_nxt = exp_id_r;
    res.status = ST_ACCEPTED;
    res.payload_valid = 1'b0;
    res.payload_byte = 8'd0;
    res.payload_index = 16'd0;
    res.ack_result = ACK_NONE;
    if (opcode == OP_ARM) begin
      ack_pending_nxt = 1'b1;
      ack_matches_nxt = 1'b0;
      exp_class_nxt = sent_class;
      exp_id_nxt = sent_id;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_byte != cfg.sync_first) res.status = ST_NOT_FRAME;
        end
        PH_SYNC2: begin
          if (rx_byte == cfg.sync_second) begin
            byte_count_nxt = 16'd0;
            sum_a_nxt = 8'd0;
            sum_b_nxt = 8'd0;
            first_bad_nxt = 1'b0;
            class_nxt = 8'd0;
            id_nxt = 8'd0;
            length_nxt = 16'd0;
          end
        end
        PH_HEAD: begin
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          if (byte_count_r == 16'd0) begin
            class_nxt = rx_byte;
            byte_count_nxt = 16'd1;
          end else if (byte_count_r == 16'd1) begin
            id_nxt = rx_byte;
            byte_count_nxt = 16'd2;
          end else if (byte_count_r == 16'd2) begin
            length_nxt = {8'd0, rx_byte};
            byte_count_nxt = 16'd3;
          end else begin
            length_nxt = full_length;
            byte_count_nxt = 16'd0;
            ack_matches_nxt = ack_pending_r && (class_r == cfg.ack_class_code);
          end
        end
        PH_DATA: begin
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          res.payload_valid = 1'b1;
          res.payload_byte = rx_byte;
          res.payload_index = byte_count_r;
          if (ack_matches_r &&
              ((byte_count_r == 16'd0 && rx_byte != exp_class_r) ||
               (byte_count_r == 16'd1 && rx_byte != exp_id_r))) begin
            ack_matches_nxt = 1'b0;
          end
          byte_count_nxt = count_inc;
        end
        PH_CRCA: begin
          if (rx_byte != sum_a_r) first_bad_nxt = 1'b1;
        end
        PH_CRCB: begin
          if (first_bad_r || rx_byte != sum_b_r) begin
            res.status = ST_CSUM_ERR;
          end else if (class_r == cfg.ack_class_code) begin
            res.status = ST_GOOD_ACK;
            if (ack_pending_r && ack_matches_r) begin
              if (id_r == cfg.ack_id_code) begin
                res.ack_result = ACK_ACK;
              end else if (id_r == cfg.nak_id_code) begin
                res.ack_result = ACK_NAK;
              end
              ack_pending_nxt = 1'b0;
            end
          end else begin
            res.status = ST_GOOD;
          end
        end
        default: res.status = ST_NOT_FRAME;
      endcase
    end
    res.frame_class = class_nxt;
    res.frame_id = id_nxt;
    res.frame_length = length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      byte_count_r <= 16'd0;
      length_r <= 16'd0;
      class_r <= 8'd0;
      id_r <= 8'd0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      first_bad_r <= 1'b0;
      ack_pending_r <= 1'b0;
      ack_matches_r <= 1'b0;
      exp_class_r <= 8'd0;
      exp_id_r <= 8'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      length_r <= length_nxt;
      class_r <= class_nxt;
      id_r <= id_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      first_bad_r <= first_bad_nxt;
      ack_pending_r <= ack_pending_nxt;
      ack_matches_r <= ack_matches_nxt;
      exp_class_r <= exp_class_nxt;
      exp_id_r <= exp_id_nxt;
    end
  end

endmodule

[hdl/ubxfr_out_reg.sv]
// Result register between the parser and the output channel.
module ubxfr_out_reg import ubxfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic in_fire,
  input  res_t res,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_res = res_r;

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

endmodule

[hdl/ubx_frame_receiver_unit.sv]
// Top level of the binary GPS frame receiver.
// Takes one word per cycle: a received byte or an arm request for an
// acknowledge wait, and gives exactly one result word for each, in the
// cycle after acceptance, from a single result register. The parser state
// advances in the same cycle the word is accepted, so a new word can enter
// every cycle; in_stall rises only while a result is held and out_stall is
// high. Configuration writes are always ready and are registered before use.
module ubx_frame_receiver_unit import ubxfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [7:0]           in_rx_byte,
  input  logic [7:0]           in_sent_class,
  input  logic [7:0]           in_sent_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic                 out_payload_valid,
  output logic [7:0]           out_payload_byte,
  output logic [15:0]          out_payload_index,
  output logic [7:0]           out_frame_class,
  output logic [7:0]           out_frame_id,
  output logic [15:0]          out_frame_length,
  output logic [1:0]           out_ack_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic in_fire;

  ubxfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ubxfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .opcode     (in_opcode),
    .rx_byte    (in_rx_byte),
    .sent_class (in_sent_class),
    .sent_id    (in_sent_id),
    .cfg        (cfg),
    .res        (res)
  );

  ubxfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_fire   (in_fire),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status = out_res.status;
  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte = out_res.payload_byte;
  assign out_payload_index = out_res.payload_index;
  assign out_frame_class = out_res.frame_class;
  assign out_frame_id = out_res.frame_id;
  assign out_frame_length = out_res.frame_length;
  assign out_ack_result = out_res.ack_result;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("Input stalled with no result held.");

  a_word_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("Accepted word produced no result.");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload_valid) |-> (out_status == ST_ACCEPTED))
    else $error("Payload byte reported with a frame end status.");

  a_ack_on_ack_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ack_result != ACK_NONE) |-> (out_status == ST_GOOD_ACK))
    else $error("Ack result outside a good acknowledge frame.");

endmodule
